>>> src/assert_macros.svh
// Assertion helpers for the RTL, used by bgd_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted
`define BGD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define BGD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/bgd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bgd_pkg;

  localparam int unsigned BGD_TIME_W    = 32;
  localparam int unsigned BGD_MS_W      = 16;
  localparam int unsigned BGD_CNT_W     = 8;
  localparam int unsigned BGD_CFG_IDX_W = 3;
  localparam int unsigned BGD_IN_TDATA_W  = 40;
  localparam int unsigned BGD_OUT_TDATA_W = 8;

  localparam logic [BGD_CNT_W-1:0] BGD_CNT_MAX = '1;

  typedef enum logic [BGD_CFG_IDX_W-1:0] {
    CFG_HOLD_MIN      = 3'd0,
    CFG_DEBOUNCE_DOWN = 3'd1,
    CFG_DEBOUNCE_UP   = 3'd2,
    CFG_DEBOUNCE_TAP  = 3'd3,
    CFG_SHAKE_COUNT   = 3'd4,
    CFG_SHAKE_WINDOW  = 3'd5
  } bgd_cfg_idx_e;

  typedef struct packed {
    logic [BGD_MS_W-1:0]  hold_min;
    logic [BGD_MS_W-1:0]  debounce_down;
    logic [BGD_MS_W-1:0]  debounce_up;
    logic [BGD_MS_W-1:0]  debounce_tap;
    logic [BGD_CNT_W-1:0] shake_count;
    logic [BGD_MS_W-1:0]  shake_window;
  } bgd_cfg_t;

  typedef struct packed {
    logic                  pressed;
    logic [BGD_TIME_W-1:0] now_ms;
  } bgd_sample_t;

  typedef struct packed {
    logic shake_event;
    logic hold_event;
    logic tap_event;
    logic up_event;
    logic down_event;
  } bgd_events_t;

endpackage

`default_nettype wire

>>> src/button_gesture_detector.sv
`timescale 1ns / 1ps
`default_nettype none

// Button gesture detector: turns a stream of timestamped button samples into
// press, release, tap, hold and shake events.
// Channels:
//   s_axis  - one sample per transaction: tdata[0] pressed, tdata[32:1] now_ms.
//   m_axis  - one event word per accepted sample, every bit zero unless that
//             event fires on this sample.
//   cfg     - write-only registers, index 0..5: hold_min, debounce_down,
//             debounce_up, debounce_tap, shake_count, shake_window.
//             Write them only while no sample is in flight.
// A sample is held in the input register and its events in the result register.
// Throughput: one sample per cycle while m_axis takes each result; the state update
// for a sample is a single pass of subtract/compare logic between the input register
// and the result register.
// Reset clears the valid flags, config registers, pending events and the tap count.
// When m_axis stalls, the result register holds; one more sample waits in the
// input register, after which s_axis_tready_o drops until the result is taken.
module button_gesture_detector (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   s_axis_tvalid_i,
  output      logic                                   s_axis_tready_o,
  // [0] pressed, [32:1] now_ms, [39:33] zero
  input  wire logic [bgd_pkg::BGD_IN_TDATA_W-1:0]     s_axis_tdata_i,
  output      logic                                   m_axis_tvalid_o,
  input  wire logic                                   m_axis_tready_i,
  // [0] down_event, [1] up_event, [2] tap_event, [3] hold_event,
  // [4] shake_event, [7:5] zero
  output      logic [bgd_pkg::BGD_OUT_TDATA_W-1:0]    m_axis_tdata_o,
  input  wire logic                                   cfg_we_i,
  input  wire logic [bgd_pkg::BGD_CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [bgd_pkg::BGD_MS_W-1:0]           cfg_wdata_i
);
  import bgd_pkg::*;

  logic        in_valid_q, in_valid_d;
  bgd_sample_t in_sample_q;
  logic        out_valid_q, out_valid_d;
  bgd_events_t out_ev_q;
  bgd_events_t ev;
  bgd_cfg_t    cfg;
  logic        advance, in_take;

  assign advance = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take = s_axis_tvalid_i && s_axis_tready_o;

  assign in_valid_d  = in_take || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_sample_q.pressed <= s_axis_tdata_i[0];
      in_sample_q.now_ms  <= s_axis_tdata_i[BGD_TIME_W:1];
    end
    if (advance) begin
      out_ev_q <= ev;
    end
  end

  bgd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bgd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .sample_i  (in_sample_q),
    .cfg_i     (cfg),
    .events_o  (ev)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_ev_q.shake_event, out_ev_q.hold_event,
                            out_ev_q.tap_event, out_ev_q.up_event, out_ev_q.down_event};

endmodule

`default_nettype wire

>>> src/bgd_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module bgd_cfg_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [bgd_pkg::BGD_CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [bgd_pkg::BGD_MS_W-1:0]        cfg_wdata_i,
  output bgd_pkg::bgd_cfg_t                        cfg_o
);
  import bgd_pkg::*;

  bgd_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (bgd_cfg_idx_e'(cfg_idx_i))
        CFG_HOLD_MIN:      cfg_d.hold_min      = cfg_wdata_i;
        CFG_DEBOUNCE_DOWN: cfg_d.debounce_down = cfg_wdata_i;
        CFG_DEBOUNCE_UP:   cfg_d.debounce_up   = cfg_wdata_i;
        CFG_DEBOUNCE_TAP:  cfg_d.debounce_tap  = cfg_wdata_i;
        CFG_SHAKE_COUNT:   cfg_d.shake_count   = cfg_wdata_i[BGD_CNT_W-1:0];
        CFG_SHAKE_WINDOW:  cfg_d.shake_window  = cfg_wdata_i;
        default:           cfg_d = cfg_q; // unmapped index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> src/bgd_core.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bgd_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            advance_i,
  input  wire bgd_pkg::bgd_sample_t sample_i,
  input  wire bgd_pkg::bgd_cfg_t    cfg_i,
  output bgd_pkg::bgd_events_t events_o
);
  import bgd_pkg::*;

  logic                  press_active_q, press_active_d;
  logic                  hold_reached_q, hold_reached_d;
  logic [BGD_TIME_W-1:0] press_start_q, press_start_d;
  logic                  down_pending_q, down_pending_d;
  logic [BGD_TIME_W-1:0] down_stamp_q, down_stamp_d;
  logic                  up_pending_q, up_pending_d;
  logic [BGD_TIME_W-1:0] up_stamp_q, up_stamp_d;
  logic                  tap_pending_q, tap_pending_d;
  logic [BGD_TIME_W-1:0] tap_stamp_q, tap_stamp_d;
  logic                  shake_valid_q, shake_valid_d;
  logic [BGD_TIME_W-1:0] shake_stamp_q, shake_stamp_d;
  logic [BGD_CNT_W-1:0]  tap_counter_q, tap_counter_d;

  logic [BGD_TIME_W-1:0] now;
  logic                  press_edge, release_edge, tap_release;
  logic [BGD_TIME_W-1:0] since_press, since_down, since_up, since_tap, since_shake;
  bgd_events_t           ev;
  logic                  hold_fire, shake_fire;

  assign now          = sample_i.now_ms;
  assign press_edge   = sample_i.pressed && !press_active_q;
  assign release_edge = !sample_i.pressed && press_active_q;
  assign tap_release  = release_edge && !hold_reached_q;

  // Stamps after the level is handled (press start: before); wrap modulo 2^32
  assign since_press = now - press_start_q;
  assign since_down  = now - down_stamp_d;
  assign since_up    = now - up_stamp_d;
  assign since_tap   = now - tap_stamp_d;
  assign since_shake = now - shake_stamp_d;

  always_comb begin
    press_active_d = press_active_q;
    hold_reached_d = hold_reached_q;
    press_start_d  = press_start_q;
    down_pending_d = down_pending_q;
    down_stamp_d   = down_stamp_q;
    up_pending_d   = up_pending_q;
    up_stamp_d     = up_stamp_q;
    tap_pending_d  = tap_pending_q;
    tap_stamp_d    = tap_stamp_q;
    shake_valid_d  = shake_valid_q;
    shake_stamp_d  = shake_stamp_q;
    tap_counter_d  = tap_counter_q;
    ev             = '0;

    if (press_edge) begin
      press_active_d = 1'b1;
      press_start_d  = now;
      down_pending_d = 1'b1;
      down_stamp_d   = now;
    end else if (sample_i.pressed && !hold_reached_q && (cfg_i.hold_min != '0) &&
                 (since_press >= BGD_TIME_W'(cfg_i.hold_min))) begin
      hold_reached_d = 1'b1;
      ev.hold_event  = 1'b1;
    end

    if (release_edge) begin
      up_pending_d   = 1'b1;
      up_stamp_d     = now;
      press_active_d = 1'b0;
      hold_reached_d = 1'b0;
    end

    if (tap_release) begin
      tap_pending_d = 1'b1;
      tap_stamp_d   = now;
      shake_valid_d = 1'b1;
      shake_stamp_d = now;
      if (tap_counter_q != BGD_CNT_MAX) begin
        tap_counter_d = tap_counter_q + 1'b1;
      end
    end

    if (down_pending_d && (since_down > BGD_TIME_W'(cfg_i.debounce_down))) begin
      down_pending_d = 1'b0;
      ev.down_event  = 1'b1;
    end
    if (up_pending_d && (since_up > BGD_TIME_W'(cfg_i.debounce_up))) begin
      up_pending_d = 1'b0;
      ev.up_event  = 1'b1;
    end
    if (tap_pending_d && (since_tap > BGD_TIME_W'(cfg_i.debounce_tap))) begin
      tap_pending_d = 1'b0;
      ev.tap_event  = 1'b1;
    end

    // Window expiry clears the count but leaves the shake armed
    if (!shake_valid_d || (since_shake > BGD_TIME_W'(cfg_i.shake_window))) begin
      tap_counter_d = '0;
    end
    if (shake_valid_d && (tap_counter_d >= cfg_i.shake_count)) begin
      shake_valid_d  = 1'b0;
      tap_counter_d  = '0;
      ev.shake_event = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_active_q <= 1'b0;
      hold_reached_q <= 1'b0;
      down_pending_q <= 1'b0;
      up_pending_q   <= 1'b0;
      tap_pending_q  <= 1'b0;
      shake_valid_q  <= 1'b0;
      tap_counter_q  <= '0;
    end else if (advance_i) begin
      press_active_q <= press_active_d;
      hold_reached_q <= hold_reached_d;
      down_pending_q <= down_pending_d;
      up_pending_q   <= up_pending_d;
      tap_pending_q  <= tap_pending_d;
      shake_valid_q  <= shake_valid_d;
      tap_counter_q  <= tap_counter_d;
    end
  end

  // Stamps only matter while their pending or armed bit is set
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      press_start_q <= press_start_d;
      down_stamp_q  <= down_stamp_d;
      up_stamp_q    <= up_stamp_d;
      tap_stamp_q   <= tap_stamp_d;
      shake_stamp_q <= shake_stamp_d;
    end
  end

  assign events_o = ev;

  assign hold_fire  = advance_i && ev.hold_event;
  assign shake_fire = advance_i && ev.shake_event;

  `BGD_ASSERT(a_hold_latches, clk_i, rst_ni, hold_fire |=> hold_reached_q, "hold not latched")
  `BGD_ASSERT(a_shake_clears, clk_i, rst_ni, shake_fire |=> !shake_valid_q, "shake left armed")
  `BGD_ASSERT_ALWAYS(a_count_armed, clk_i, |tap_counter_q |-> shake_valid_q, "count not armed")

endmodule

`default_nettype wire

>>> tb/sv/button_gesture_detector_tb.sv
`timescale 1ns / 1ps

module button_gesture_detector_tb;
  import bgd_pkg::*;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  // Indexes past the last register; writes to them must leave every register alone
  localparam logic [BGD_CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [BGD_CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 60;
  localparam int CHUNK_ITEMS   = 20;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  // [0] pressed, [32:1] now_ms, [39:33] zero
  logic [BGD_IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  // [0] down_event, [1] up_event, [2] tap_event, [3] hold_event, [4] shake_event, [7:5] zero
  logic [BGD_OUT_TDATA_W-1:0] m_axis_tdata;
  logic                       cfg_we = 1'b0;
  logic [BGD_CFG_IDX_W-1:0]   cfg_idx = '0;
  logic [BGD_MS_W-1:0]        cfg_wdata = '0;

  button_gesture_detector dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // Register copies
  logic [BGD_MS_W-1:0]   hold_min_ms;
  logic [BGD_MS_W-1:0]   down_delay_ms;
  logic [BGD_MS_W-1:0]   up_delay_ms;
  logic [BGD_MS_W-1:0]   tap_delay_ms;
  logic [BGD_CNT_W-1:0]  shake_target;
  logic [BGD_MS_W-1:0]   shake_window_ms;

  // Gesture state
  logic                  btn_down;
  logic [BGD_TIME_W-1:0] press_start_ms;
  logic                  hold_seen;
  logic                  down_armed;
  logic [BGD_TIME_W-1:0] down_at_ms;
  logic                  up_armed;
  logic [BGD_TIME_W-1:0] up_at_ms;
  logic                  tap_armed;
  logic [BGD_TIME_W-1:0] tap_at_ms;
  logic                  shake_armed;
  logic [BGD_TIME_W-1:0] last_tap_ms;
  logic [BGD_CNT_W-1:0]  tap_tally;

  bgd_sample_t           button_samples[$];
  bgd_events_t           predicted_events[$];
  int                    samples_sent = 0;
  int                    samples_taken = 0;
  int                    error_count = 0;
  int                    results_seen = 0;
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  logic [BGD_TIME_W-1:0] clock_ms;
  int unsigned           max_gap_ms;

  function automatic bgd_events_t predict_gesture(input logic pressed,
                                                  input logic [BGD_TIME_W-1:0] now);
    bgd_events_t ev;
    ev = '0;
    if (pressed) begin
      if (!btn_down) begin
        btn_down = 1'b1;
        press_start_ms = now;
        down_armed = 1'b1;
        down_at_ms = now;
      end else if (!hold_seen && hold_min_ms != '0 &&
                   BGD_TIME_W'(now - press_start_ms) >= BGD_TIME_W'(hold_min_ms)) begin
        hold_seen = 1'b1;
        ev.hold_event = 1'b1;
      end
    end else if (btn_down) begin
      up_armed = 1'b1;
      up_at_ms = now;
      // a press that became a hold is not a tap
      if (!hold_seen) begin
        tap_armed = 1'b1;
        tap_at_ms = now;
        shake_armed = 1'b1;
        last_tap_ms = now;
        if (tap_tally != BGD_CNT_MAX) tap_tally = tap_tally + 1'b1;
      end
      btn_down = 1'b0;
      hold_seen = 1'b0;
    end

    if (down_armed && BGD_TIME_W'(now - down_at_ms) > BGD_TIME_W'(down_delay_ms)) begin
      down_armed = 1'b0;
      ev.down_event = 1'b1;
    end
    if (up_armed && BGD_TIME_W'(now - up_at_ms) > BGD_TIME_W'(up_delay_ms)) begin
      up_armed = 1'b0;
      ev.up_event = 1'b1;
    end
    if (tap_armed && BGD_TIME_W'(now - tap_at_ms) > BGD_TIME_W'(tap_delay_ms)) begin
      tap_armed = 1'b0;
      ev.tap_event = 1'b1;
    end
    // window expiry clears the tally but keeps the shake armed
    if (!shake_armed || BGD_TIME_W'(now - last_tap_ms) > BGD_TIME_W'(shake_window_ms))
      tap_tally = '0;
    if (shake_armed && tap_tally >= shake_target) begin
      shake_armed = 1'b0;
      tap_tally = '0;
      ev.shake_event = 1'b1;
    end
    return ev;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  task automatic check_flag(input string name, input logic got, input logic want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %b want %b", results_seen, name, got, want));
  endtask

  function automatic bit link_idle();
    return button_samples.size() == 0 && samples_sent == samples_taken &&
           predicted_events.size() == 0;
  endfunction

  // Driver: hold a transaction until it is taken, then maybe idle
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && samples_sent != samples_taken)) begin
      if (button_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata  <= {7'b0, button_samples[0].now_ms, button_samples[0].pressed};
        s_axis_tvalid <= 1'b1;
        samples_sent  = samples_sent + 1;
        void'(button_samples.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor
  always @(posedge clk_i) begin
    bgd_events_t got;
    bgd_events_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = bgd_events_t'(m_axis_tdata[4:0]);
        if (predicted_events.size() == 0) begin
          report_mismatch($sformatf("result %b with no sample outstanding", m_axis_tdata));
        end else begin
          want = predicted_events.pop_front();
          check_flag("down_event", got.down_event, want.down_event);
          check_flag("up_event", got.up_event, want.up_event);
          check_flag("tap_event", got.tap_event, want.tap_event);
          check_flag("hold_event", got.hold_event, want.hold_event);
          check_flag("shake_event", got.shake_event, want.shake_event);
        end
        results_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_events.push_back(predict_gesture(s_axis_tdata[0], s_axis_tdata[32:1]));
        samples_taken <= samples_taken + 1;
      end
    end
  end

  task automatic write_register(input logic [BGD_CFG_IDX_W-1:0] idx,
                                input logic [BGD_MS_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_HOLD_MIN:      hold_min_ms = data;
      CFG_DEBOUNCE_DOWN: down_delay_ms = data;
      CFG_DEBOUNCE_UP:   up_delay_ms = data;
      CFG_DEBOUNCE_TAP:  tap_delay_ms = data;
      CFG_SHAKE_COUNT:   shake_target = data[BGD_CNT_W-1:0];
      CFG_SHAKE_WINDOW:  shake_window_ms = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input int unsigned hold, input int unsigned down,
                           input int unsigned up, input int unsigned tap,
                           input int unsigned count, input int unsigned window);
    write_register(CFG_HOLD_MIN, BGD_MS_W'(hold));
    write_register(CFG_DEBOUNCE_DOWN, BGD_MS_W'(down));
    write_register(CFG_DEBOUNCE_UP, BGD_MS_W'(up));
    write_register(CFG_DEBOUNCE_TAP, BGD_MS_W'(tap));
    write_register(CFG_SHAKE_COUNT, BGD_MS_W'(count));
    write_register(CFG_SHAKE_WINDOW, BGD_MS_W'(window));
    write_register($urandom_range(1) ? CFG_IDX_SPARE_HI : CFG_IDX_SPARE_LO,
                   BGD_MS_W'($urandom()));
  endtask

  task automatic wait_for_drain();
    do @(negedge clk_i); while (!link_idle());
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      IDLE_SEND: begin send_idle_pct = 45; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 45; end
      IDLE_BOTH: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
      default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  task automatic push_sample(input logic pressed, input logic [BGD_TIME_W-1:0] now);
    bgd_sample_t smp;
    smp.pressed = pressed;
    smp.now_ms  = now;
    button_samples.push_back(smp);
  endtask

  task automatic tick_clock();
    clock_ms += $urandom_range(0, max_gap_ms);
    if ($urandom_range(7) == 0) clock_ms += $urandom_range(0, 4 * max_gap_ms);
  endtask

  // Mostly press/release gestures on a running clock, with some stray samples
  task automatic queue_gestures(input int count);
    int n;
    int k;
    n = 0;
    while (n < count) begin
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1)) clock_ms = $urandom();
        push_sample(1'($urandom_range(1)), $urandom_range(1) ? clock_ms : $urandom());
        n++;
      end else begin
        k = $urandom_range(1, 6);
        repeat (k) begin
          tick_clock();
          push_sample(1'b1, clock_ms);
        end
        n += k;
        k = $urandom_range(1, 4);
        repeat (k) begin
          tick_clock();
          push_sample(1'b0, clock_ms);
        end
        n += k;
      end
    end
  endtask

  task automatic random_settings(input int phase);
    case (phase)
      0: begin
        configure('0, '0, '0, '0, '0, '0);
        max_gap_ms = 3;
      end
      2: begin
        configure('1, '1, '1, '1, '1, '1);
        max_gap_ms = 30000;
        clock_ms = 32'hFFFF_0000;
      end
      3: begin
        configure($urandom_range(1, 40), $urandom_range(15), $urandom_range(15),
                  $urandom_range(15), '0, $urandom_range(5, 60));
        max_gap_ms = 12;
      end
      4: begin
        configure($urandom_range(1, 40), $urandom_range(15), $urandom_range(15),
                  $urandom_range(15), $urandom_range(1, 3), $urandom_range(5));
        max_gap_ms = 8;
      end
      5: begin
        configure($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        max_gap_ms = 70000;
      end
      7: begin
        configure($urandom_range(1, 3), $urandom_range(15), $urandom_range(15),
                  $urandom_range(15), $urandom_range(1, 5), $urandom_range(5, 60));
        max_gap_ms = 12;
      end
      default: begin
        configure($urandom_range(1, 40), $urandom_range(15), $urandom_range(15),
                  $urandom_range(15), $urandom_range(1, 5), $urandom_range(5, 60));
        max_gap_ms = 12;
        if (phase == 6) clock_ms = 32'hFFFF_FFC0;
      end
    endcase
  endtask

  initial begin
    hold_min_ms = '0; down_delay_ms = '0; up_delay_ms = '0; tap_delay_ms = '0;
    shake_target = '0; shake_window_ms = '0;
    btn_down = 1'b0; press_start_ms = '0; hold_seen = 1'b0;
    down_armed = 1'b0; down_at_ms = '0; up_armed = 1'b0; up_at_ms = '0;
    tap_armed = 1'b0; tap_at_ms = '0; shake_armed = 1'b0; last_tap_ms = '0;
    tap_tally = '0;
    clock_ms = '0;
    max_gap_ms = 1;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Short presses, a hold, a double tap to shake, window expiry, clock wrap
    set_idling(IDLE_NONE);
    configure(16'd5, 16'd2, 16'd3, 16'd1, 16'd2, 16'd20);
    push_sample(1'b1, 32'd0);
    push_sample(1'b1, 32'd2);
    push_sample(1'b1, 32'd3);
    push_sample(1'b1, 32'd5);
    push_sample(1'b0, 32'd6);
    push_sample(1'b0, 32'd10);
    push_sample(1'b1, 32'd11);
    push_sample(1'b0, 32'd12);
    push_sample(1'b0, 32'd14);
    push_sample(1'b1, 32'd15);
    push_sample(1'b0, 32'd16);
    push_sample(1'b1, 32'd17);
    push_sample(1'b0, 32'd18);
    push_sample(1'b0, 32'd60);
    push_sample(1'b1, 32'hFFFF_FFFE);
    push_sample(1'b1, 32'hFFFF_FFFF);
    push_sample(1'b0, 32'h0000_0003);
    wait_for_drain();

    // Holds off, and a shake on every tap
    write_register(CFG_HOLD_MIN, '0);
    write_register(CFG_SHAKE_COUNT, '0);
    push_sample(1'b1, 32'd100);
    push_sample(1'b1, 32'd40000);
    push_sample(1'b0, 32'd40001);
    push_sample(1'b1, 32'd40002);
    push_sample(1'b0, 32'd40002);
    push_sample(1'b0, 32'd40010);
    wait_for_drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_settings(phase);
      for (int chunk = 0; chunk * CHUNK_ITEMS < PHASE_ITEMS; chunk++) begin
        set_idling((chunk + phase) % 4);
        queue_gestures(CHUNK_ITEMS);
        // let the results catch up once per phase before sending more
        if (chunk == 1) wait_for_drain();
        else do @(negedge clk_i); while (button_samples.size() != 0);
      end
      wait_for_drain();
    end

    set_idling(IDLE_NONE);
    wait_for_drain();
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && predicted_events.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[%0t] timeout", $realtime);
    $display("TEST FAILED");
    $finish;
  end

endmodule
